/* src/ftbsl_pkg.sv */
`default_nettype none
package ftbsl_pkg;

  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int STEP_FRAC_BITS_DEF = 30;

  typedef enum logic [1:0] {
    PAIR_KEEP,
    PAIR_ZERO,
    PAIR_DIVIDE
  } pair_kind_t;

  typedef struct packed {
    pair_kind_t dual_kind;
    pair_kind_t slack_kind;
    logic       last_item;
  } item_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

/* src/ftbsl_if.sv */
`default_nettype none
interface ftbsl_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] dual_value;
  logic signed [VALUE_WIDTH-1:0] dual_dir;
  logic signed [VALUE_WIDTH-1:0] slack_value;
  logic signed [VALUE_WIDTH-1:0] slack_dir;
  logic                          last_item;

  modport source (output valid, dual_value, dual_dir, slack_value, slack_dir, last_item,
                  input ready);
  modport sink   (input valid, dual_value, dual_dir, slack_value, slack_dir, last_item,
                  output ready);
endinterface

interface ftbsl_out_if #(
  parameter int STEP_FRAC_BITS = 30
);
  logic                    valid;
  logic                    ready;
  logic [STEP_FRAC_BITS:0] primal_step;
  logic [STEP_FRAC_BITS:0] dual_step;
  logic [STEP_FRAC_BITS:0] common_step;

  modport source (output valid, primal_step, dual_step, common_step, input ready);
  modport sink   (input valid, primal_step, dual_step, common_step, output ready);
endinterface
`default_nettype wire

/* src/fraction_to_boundary_step_length.sv */
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    dual_value, dual_dir, slack_value, slack_dir, last_item
// out_ch   out  valid/ready    primal_step, dual_step, common_step
//
// An item with a divide goes through load, one quotient bit per cycle in the pair of restoring
// dividers (dual and slack side by side), and commit in the back end; others skip the divide.
// The two-entry queue accepts transactions while the back end divides, until it is full.
// Synchronous active-low reset sets both running steps to one and empties queue and output.
// A stalled output register holds the commit of the next last item only.
`default_nettype none
module fraction_to_boundary_step_length import ftbsl_pkg::*; #(
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ftbsl_in_if.sink    in_ch,
  ftbsl_out_if.source out_ch
);

  localparam int DATA_W = 4 * VALUE_WIDTH;

  logic              push_valid, push_ready;
  item_ctl_t         push_ctl;
  logic [DATA_W-1:0] push_data;
  logic              pop_valid, pop_ready;
  item_ctl_t         pop_ctl;
  logic [DATA_W-1:0] pop_data;

  ftbsl_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_ctl   (push_ctl),
    .push_data  (push_data)
  );

  ftbsl_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ctl    (pop_ctl),
    .pop_data   (pop_data)
  );

  ftbsl_back #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_ctl   (pop_ctl),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

/* src/ftbsl_front.sv */
`default_nettype none
module ftbsl_front import ftbsl_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  ftbsl_in_if.sink               in_ch,
  input  wire logic              push_ready,
  output logic                   push_valid,
  output item_ctl_t              push_ctl,
  output logic [4*VALUE_WIDTH-1:0] push_data
);

  logic [VALUE_WIDTH-1:0] dual_mag;
  logic [VALUE_WIDTH-1:0] slack_mag;

  function automatic pair_kind_t classify(input logic [VALUE_WIDTH-1:0] value,
                                          input logic [VALUE_WIDTH-1:0] dir,
                                          input logic [VALUE_WIDTH-1:0] mag);
    pair_kind_t kind;
    priority if (!dir[VALUE_WIDTH-1]) begin
      kind = PAIR_KEEP;
    end else if (value[VALUE_WIDTH-1]) begin
      kind = PAIR_ZERO;
    end else if (value >= mag) begin
      kind = PAIR_KEEP;
    end else begin
      kind = PAIR_DIVIDE;
    end
    return kind;
  endfunction

  assign dual_mag  = ~in_ch.dual_dir + VALUE_WIDTH'(1);
  assign slack_mag = ~in_ch.slack_dir + VALUE_WIDTH'(1);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_ctl.dual_kind  = classify(in_ch.dual_value, in_ch.dual_dir, dual_mag);
    push_ctl.slack_kind = classify(in_ch.slack_value, in_ch.slack_dir, slack_mag);
    push_ctl.last_item  = in_ch.last_item;
    push_data = {in_ch.dual_value, dual_mag, in_ch.slack_value, slack_mag};
  end

endmodule
`default_nettype wire

/* src/ftbsl_queue.sv */
`default_nettype none
module ftbsl_queue import ftbsl_pkg::*; #(
  parameter int DATA_W = 4 * VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire item_ctl_t         push_ctl,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output item_ctl_t              pop_ctl,
  output logic [DATA_W-1:0]      pop_data
);

  item_ctl_t         ctl_r  [2];
  logic [DATA_W-1:0] data_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_ctl    = ctl_r[rd_ptr_r];
  assign pop_data   = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_r[wr_ptr_r]  <= push_ctl;
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* src/ftbsl_back.sv */
`default_nettype none
module ftbsl_back import ftbsl_pkg::*; #(
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     pop_valid,
  output logic                          pop_ready,
  input  wire item_ctl_t                pop_ctl,
  input  wire logic [4*VALUE_WIDTH-1:0] pop_data,
  ftbsl_out_if.source                   out_ch
);

  localparam int SW    = STEP_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEP_FRAC_BITS + 1);
  localparam logic [SW-1:0] STEP_ONE = {1'b1, {STEP_FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_FRAC_BITS - 1);

  back_state_t            state_r, state_nxt;
  item_ctl_t              ctl_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] dual_rem_r, dual_rem_nxt, dual_div_r;
  logic [VALUE_WIDTH-1:0] slack_rem_r, slack_rem_nxt, slack_div_r;
  logic [STEP_FRAC_BITS-1:0] dual_quo_r, dual_quo_nxt;
  logic [STEP_FRAC_BITS-1:0] slack_quo_r, slack_quo_nxt;
  logic [SW-1:0]          run_dual_r, run_primal_r;
  logic [SW-1:0]          new_dual, new_primal;
  logic [SW-1:0]          primal_r, dual_r, common_r;
  logic                   out_valid_r;
  logic                   load, iterate, commit, out_free;

  function automatic logic [VALUE_WIDTH:0] div_step(input logic [VALUE_WIDTH-1:0] rem,
                                                    input logic [VALUE_WIDTH-1:0] div);
    logic [VALUE_WIDTH:0] shifted;
    logic [VALUE_WIDTH:0] diff;
    logic                 ge;
    shifted = {rem, 1'b0};
    diff    = shifted - {1'b0, div};
    ge      = (shifted >= {1'b0, div});
    return {ge, ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0]};
  endfunction

  function automatic logic [SW-1:0] next_step(input pair_kind_t kind,
                                              input logic [STEP_FRAC_BITS-1:0] quo,
                                              input logic [SW-1:0] run);
    logic [SW-1:0] q;
    logic [SW-1:0] res;
    q = {1'b0, quo};
    unique case (kind)
      PAIR_ZERO:   res = '0;
      PAIR_DIVIDE: res = (q < run) ? q : run;
      default:     res = run;
    endcase
    return res;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          state_nxt = (pop_ctl.dual_kind == PAIR_DIVIDE || pop_ctl.slack_kind == PAIR_DIVIDE)
                      ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ctl_r.last_item || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    iterate = 1'b0;
    commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: load    = pop_valid;
      ST_DIV:  iterate = 1'b1;
      ST_DONE: commit  = !ctl_r.last_item || out_free;
      default: ;
    endcase
  end

  assign pop_ready = load;

  always_comb begin
    logic [VALUE_WIDTH:0] ds;
    logic [VALUE_WIDTH:0] ss;
    ds = div_step(dual_rem_r, dual_div_r);
    ss = div_step(slack_rem_r, slack_div_r);
    dual_rem_nxt  = ds[VALUE_WIDTH-1:0];
    slack_rem_nxt = ss[VALUE_WIDTH-1:0];
    dual_quo_nxt  = {dual_quo_r[STEP_FRAC_BITS-2:0], ds[VALUE_WIDTH]};
    slack_quo_nxt = {slack_quo_r[STEP_FRAC_BITS-2:0], ss[VALUE_WIDTH]};
    cnt_nxt       = cnt_r + CNT_W'(1);
    new_dual      = next_step(ctl_r.dual_kind, dual_quo_r, run_dual_r);
    new_primal    = next_step(ctl_r.slack_kind, slack_quo_r, run_primal_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      run_dual_r   <= STEP_ONE;
      run_primal_r <= STEP_ONE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        run_dual_r   <= ctl_r.last_item ? STEP_ONE : new_dual;
        run_primal_r <= ctl_r.last_item ? STEP_ONE : new_primal;
      end
      if (commit && ctl_r.last_item) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r       <= pop_ctl;
      cnt_r       <= '0;
      dual_rem_r  <= pop_data[4*VALUE_WIDTH-1:3*VALUE_WIDTH];
      dual_div_r  <= pop_data[3*VALUE_WIDTH-1:2*VALUE_WIDTH];
      slack_rem_r <= pop_data[2*VALUE_WIDTH-1:VALUE_WIDTH];
      slack_div_r <= pop_data[VALUE_WIDTH-1:0];
      dual_quo_r  <= '0;
      slack_quo_r <= '0;
    end else if (iterate) begin
      cnt_r       <= cnt_nxt;
      dual_rem_r  <= dual_rem_nxt;
      slack_rem_r <= slack_rem_nxt;
      dual_quo_r  <= dual_quo_nxt;
      slack_quo_r <= slack_quo_nxt;
    end
    if (commit && ctl_r.last_item) begin
      primal_r <= new_primal;
      dual_r   <= new_dual;
      common_r <= (new_primal < new_dual) ? new_primal : new_dual;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.primal_step = primal_r;
  assign out_ch.dual_step   = dual_r;
  assign out_ch.common_step = common_r;

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ftbsl_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int SF = STEP_FRAC_BITS_DEF;

  localparam logic signed [VW-1:0] Q_ONE = VW'(1) << 16;
  localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [SF:0]          STEP_ONE = (SF+1)'(1) << SF;

  typedef struct packed {
    logic [SF:0] primal;
    logic [SF:0] dual;
    logic [SF:0] common;
  } step_triple_t;

  logic clk = 1'b0;
  logic rst_n;

  ftbsl_in_if  #(.VALUE_WIDTH(VW))    in_bus ();
  ftbsl_out_if #(.STEP_FRAC_BITS(SF)) out_bus ();

  fraction_to_boundary_step_length #(
    .VALUE_WIDTH   (VW),
    .STEP_FRAC_BITS(SF)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  always #6 clk = ~clk;

  logic [SF:0]  dual_bound;
  logic [SF:0]  primal_bound;
  step_triple_t pending_steps[$];
  int           fail_count = 0;
  int           items_sent = 0;
  bit           src_idle_on = 1'b1;
  bit           sink_idle_on = 1'b1;
  int           sink_stall = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [SF:0] limit_step(input logic signed [VW-1:0] value,
                                             input logic signed [VW-1:0] dir,
                                             input logic [SF:0]          step);
    logic [VW:0]    mag;
    logic [VW+SF:0] quot;
    if (dir >= 0) return step;
    mag = -{dir[VW-1], dir};
    if (value < 0) return '0;
    if ({1'b0, value} >= mag) return step;
    quot = {value, {SF{1'b0}}} / mag;
    return (quot[SF:0] < step) ? quot[SF:0] : step;
  endfunction

  task automatic apply_constraint(input logic signed [VW-1:0] dv, input logic signed [VW-1:0] dd,
                                  input logic signed [VW-1:0] sv, input logic signed [VW-1:0] sd,
                                  input logic last);
    step_triple_t res;
    dual_bound   = limit_step(dv, dd, dual_bound);
    primal_bound = limit_step(sv, sd, primal_bound);
    if (last) begin
      res.primal = primal_bound;
      res.dual   = dual_bound;
      res.common = (primal_bound < dual_bound) ? primal_bound : dual_bound;
      pending_steps.push_back(res);
      dual_bound   = STEP_ONE;
      primal_bound = STEP_ONE;
    end
  endtask

  task automatic send_constraint(input logic signed [VW-1:0] dv, input logic signed [VW-1:0] dd,
                                 input logic signed [VW-1:0] sv, input logic signed [VW-1:0] sd,
                                 input logic last);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.dual_value  <= dv;
    in_bus.dual_dir    <= dd;
    in_bus.slack_value <= sv;
    in_bus.slack_dir   <= sd;
    in_bus.last_item   <= last;
    do @(posedge clk); while (!in_bus.ready);
    apply_constraint(dv, dd, sv, sd, last);
    items_sent++;
  endtask

  // hold ready low in bursts of random length
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_bus.ready <= 1'b0;
      sink_stall--;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      out_bus.ready <= 1'b0;
      sink_stall = $urandom_range(0, 7);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    step_triple_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_steps.size() == 0) begin
        report("unexpected result primal_step", out_bus.primal_step, 0);
      end else begin
        want = pending_steps.pop_front();
        if (out_bus.primal_step !== want.primal)
          report("primal_step", out_bus.primal_step, want.primal);
        if (out_bus.dual_step !== want.dual)
          report("dual_step", out_bus.dual_step, want.dual);
        if (out_bus.common_step !== want.common)
          report("common_step", out_bus.common_step, want.common);
      end
    end
  end

  function automatic logic signed [VW-1:0] rand_extreme();
    case ($urandom_range(0, 4))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic signed [VW-1:0] rand_magnitude();
    return VW'($urandom()) >> $urandom_range(1, VW - 1);
  endfunction

  function automatic logic signed [VW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return VW'($urandom());
      1:       return rand_extreme();
      2:       return -rand_magnitude();
      default: return rand_magnitude();
    endcase
  endfunction

  function automatic logic signed [VW-1:0] rand_direction();
    case ($urandom_range(0, 11))
      0:       return VW'($urandom());
      1:       return '0;
      2:       return rand_magnitude();
      3:       return rand_extreme();
      default: return -(rand_magnitude() + 1);
    endcase
  endfunction

  task automatic send_random_set(input bit noise);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if (noise)
        send_constraint(VW'($urandom()), VW'($urandom()), VW'($urandom()), VW'($urandom()),
                        i == len - 1);
      else
        send_constraint(rand_operand(), rand_direction(), rand_operand(), rand_direction(),
                        i == len - 1);
    end
  endtask

  task automatic test_direction_signs();
    send_constraint(Q_ONE, '0, Q_ONE, '0, 1'b1);
    send_constraint(Q_ONE, 2 * Q_ONE, V_MAX, V_MAX, 1'b1);
    send_constraint(VW'(32'h4000_0000), V_MIN, VW'(32'h0000_8000), V_MIN, 1'b1);
    send_constraint('0, -1, V_MAX, V_MIN, 1'b1);
  endtask

  task automatic test_saturation();
    send_constraint(-1, -1, V_MIN, -Q_ONE, 1'b0);
    send_constraint(Q_ONE, -2 * Q_ONE, Q_ONE, -4 * Q_ONE, 1'b1);
    send_constraint(V_MIN, 1, -1, '0, 1'b1);
    send_constraint(V_MIN, V_MIN, Q_ONE, -3 * Q_ONE, 1'b1);
  endtask

  task automatic test_ratio_bounds();
    send_constraint(2 * Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, 1'b0);
    send_constraint(3 * Q_ONE, -4 * Q_ONE, Q_ONE, -3 * Q_ONE, 1'b0);
    send_constraint(6 * Q_ONE, -8 * Q_ONE, 2 * Q_ONE, -6 * Q_ONE, 1'b0);
    send_constraint(V_MAX, V_MIN, 1, V_MIN, 1'b1);
    send_constraint(1, -V_MAX, V_MAX - 1, -V_MAX, 1'b1);
    send_constraint(V_MAX, -V_MAX, Q_ONE, -Q_ONE - 1, 1'b1);
  endtask

  task automatic test_single_item_sets();
    send_constraint(VW'(32'h5555_5555), VW'(32'haaaa_aaaa), VW'(32'h2aaa_aaaa), VW'(32'hd555_5555),
                    1'b1);
    send_constraint(VW'(32'h0000_0001), VW'(32'hffff_fffe), VW'(32'h7fff_0000), VW'(32'h8000_0001),
                    1'b1);
    send_constraint(rand_magnitude(), -(rand_magnitude() + 1), rand_magnitude(),
                    -(rand_magnitude() + 1), 1'b1);
  endtask

  task automatic test_random_sets();
    while (items_sent < 1020) begin
      if ($urandom_range(0, 5) == 0) src_idle_on = ~src_idle_on;
      if ($urandom_range(0, 5) == 0) sink_idle_on = ~sink_idle_on;
      send_random_set($urandom_range(0, 9) == 0);
    end
  endtask

  task automatic test_steady_stream();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    while (items_sent < 1150) send_random_set(1'b0);
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (2 * SF + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.dual_value  = '0;
    in_bus.dual_dir    = '0;
    in_bus.slack_value = '0;
    in_bus.slack_dir   = '0;
    in_bus.last_item   = 1'b0;
    out_bus.ready      = 1'b0;
    dual_bound         = STEP_ONE;
    primal_bound       = STEP_ONE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_direction_signs();
    test_saturation();
    test_ratio_bounds();
    test_single_item_sets();
    test_random_sets();
    test_steady_stream();
    finish_run();
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

/* fraction_to_boundary_step_length.f */
src/ftbsl_pkg.sv
src/ftbsl_if.sv
src/ftbsl_front.sv
src/ftbsl_queue.sv
src/ftbsl_back.sv
src/fraction_to_boundary_step_length.sv
tb/sv/testbench.sv
